@@ hw/rtl/bbs_pkg.sv @@
// Package for the bounding box / bounding sphere block.
// Holds the item structs, fixed datapath widths and the sequencer state type.
// No dependencies.
package bbs_pkg;

  localparam int COORD_BITS = 16;
  localparam int EXT_BITS   = COORD_BITS - 1;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;
  localparam int ROOT_BITS  = SUM_BITS / 2;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int ITER_BITS  = $clog2(ROOT_BITS);
  localparam int PT_BITS    = 3 * COORD_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic                         last_point;
  } bbs_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic        [EXT_BITS-1:0]   extent_x;
    logic        [EXT_BITS-1:0]   extent_y;
    logic        [EXT_BITS-1:0]   extent_z;
    logic        [COORD_BITS-1:0] radius;
    logic                         overflow;
  } bbs_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CENTER,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_CMP,
    ST_SQRT,
    ST_DONE
  } bbs_state_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

@@ hw/rtl/bbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bounding_box_sphere.sv @@
// Axis-aligned bounding box and bounding sphere of a point set (signed Q8.8).
// Depends on bbs_pkg and bbs_ram.
//
// Points are taken one per cycle, stored, and folded into running per-axis
// min/max. After the item carrying last_point, in_ready drops while a small
// sequencer computes the box center floor((min+max)/2), then walks the stored
// points through one shared 17x17 multiplier (per stored point: read, then
// square and accumulate for each axis, then compare against the running
// maximum), then takes the integer square root of the largest squared
// distance, two bits per cycle. The input stays closed until the result
// enters the output register, including any wait for a previous result
// still held there. Points beyond MAX_POINTS are dropped and flagged in
// the overflow field. No clearing pass after reset.
module bounding_box_sphere #(
  parameter int MAX_POINTS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bbs_pkg::bbs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bbs_pkg::bbs_out_t out_data
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW     = bbs_pkg::COORD_BITS;
  localparam int DW     = bbs_pkg::DIFF_BITS;
  localparam int SQW    = bbs_pkg::SQ_BITS;
  localparam int SUMW   = bbs_pkg::SUM_BITS;
  localparam int RTW    = bbs_pkg::ROOT_BITS;
  localparam int RMW    = bbs_pkg::REM_BITS;
  localparam int ITW    = bbs_pkg::ITER_BITS;

  bbs_pkg::bbs_state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;
  logic signed [CW-1:0] min_x_r, min_y_r, min_z_r, max_x_r, max_y_r, max_z_r;
  logic signed [CW-1:0] min_x_nxt, min_y_nxt, min_z_nxt;
  logic signed [CW-1:0] max_x_nxt, max_y_nxt, max_z_nxt;
  logic signed [CW-1:0] cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic [1:0]       ax_r, ax_nxt;
  logic [SQW-1:0]   sq_r, sq_nxt;
  logic [SUMW-1:0]  sum_r, sum_nxt;
  logic [SUMW-1:0]  best_r, best_nxt;
  logic [SUMW-1:0]  val_r, val_nxt;
  logic [RMW-1:0]   rem_r, rem_nxt;
  logic [RTW-1:0]   root_r, root_nxt;
  logic [ITW-1:0]   it_r, it_nxt;
  logic             out_valid_r, out_valid_nxt;
  bbs_pkg::bbs_out_t out_data_r, out_data_nxt;

  // point store
  logic                        ram_we, ram_re;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [bbs_pkg::PT_BITS-1:0] ram_rdata;

  logic accept, full;
  logic signed [CW-1:0] rd_x, rd_y, rd_z, p_sel, c_sel;
  logic signed [DW-1:0] diff;
  logic signed [2*DW-1:0] prod;
  logic [DW-1:0] sum_cx, sum_cy, sum_cz, span_x, span_y, span_z;
  logic [RMW-1:0] rem_sh, trial;

  assign full   = (cnt_r == CNT_W'(MAX_POINTS));
  assign accept = in_valid && in_ready;
  assign ram_we = accept && !full;

  bbs_ram #(
    .WIDTH(bbs_pkg::PT_BITS),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata({in_data.point_x, in_data.point_y, in_data.point_z}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_x = ram_rdata[3*CW-1:2*CW];
  assign rd_y = ram_rdata[2*CW-1:CW];
  assign rd_z = ram_rdata[CW-1:0];

  // shared squarer datapath
  always_comb begin
    case (ax_r)
      bbs_pkg::AXIS_X: begin
        p_sel = rd_x;
        c_sel = cx_r;
      end
      bbs_pkg::AXIS_Y: begin
        p_sel = rd_y;
        c_sel = cy_r;
      end
      default: begin
        p_sel = rd_z;
        c_sel = cz_r;
      end
    endcase
  end

  assign diff = {p_sel[CW-1], p_sel} - {c_sel[CW-1], c_sel};
  assign prod = diff * diff;

  assign sum_cx = {min_x_r[CW-1], min_x_r} + {max_x_r[CW-1], max_x_r};
  assign sum_cy = {min_y_r[CW-1], min_y_r} + {max_y_r[CW-1], max_y_r};
  assign sum_cz = {min_z_r[CW-1], min_z_r} + {max_z_r[CW-1], max_z_r};
  assign span_x = {max_x_r[CW-1], max_x_r} - {min_x_r[CW-1], min_x_r};
  assign span_y = {max_y_r[CW-1], max_y_r} - {min_y_r[CW-1], min_y_r};
  assign span_z = {max_z_r[CW-1], max_z_r} - {min_z_r[CW-1], min_z_r};

  // one digit-pair of the restoring square root
  assign rem_sh = {rem_r[RMW-3:0], val_r[SUMW-1:SUMW-2]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    ovf_nxt       = ovf_r;
    min_x_nxt     = min_x_r;
    min_y_nxt     = min_y_r;
    min_z_nxt     = min_z_r;
    max_x_nxt     = max_x_r;
    max_y_nxt     = max_y_r;
    max_z_nxt     = max_z_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    ax_nxt        = ax_r;
    sq_nxt        = sq_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    it_nxt        = it_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[ADDR_W-1:0];

    unique case (state_r)
      bbs_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        // ready is always high here, so valid alone marks the item
        if (in_valid) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
            if (cnt_r == '0) begin
              min_x_nxt = in_data.point_x;
              min_y_nxt = in_data.point_y;
              min_z_nxt = in_data.point_z;
              max_x_nxt = in_data.point_x;
              max_y_nxt = in_data.point_y;
              max_z_nxt = in_data.point_z;
            end else begin
              if (in_data.point_x < min_x_r) min_x_nxt = in_data.point_x;
              if (in_data.point_y < min_y_r) min_y_nxt = in_data.point_y;
              if (in_data.point_z < min_z_r) min_z_nxt = in_data.point_z;
              if (in_data.point_x > max_x_r) max_x_nxt = in_data.point_x;
              if (in_data.point_y > max_y_r) max_y_nxt = in_data.point_y;
              if (in_data.point_z > max_z_r) max_z_nxt = in_data.point_z;
            end
          end
          if (in_data.last_point) begin
            state_nxt = bbs_pkg::ST_CENTER;
          end
        end
      end

      bbs_pkg::ST_CENTER: begin
        // arithmetic shift of the 17-bit sum gives the floor
        cx_nxt    = sum_cx[DW-1:1];
        cy_nxt    = sum_cy[DW-1:1];
        cz_nxt    = sum_cz[DW-1:1];
        idx_nxt   = '0;
        best_nxt  = '0;
        state_nxt = bbs_pkg::ST_READ;
      end

      bbs_pkg::ST_READ: begin
        ram_re    = 1'b1;
        ax_nxt    = bbs_pkg::AXIS_X;
        sum_nxt   = '0;
        state_nxt = bbs_pkg::ST_MUL;
      end

      bbs_pkg::ST_MUL: begin
        // |diff| never exceeds half the box span, rounded up, so the square fits
        sq_nxt    = prod[SQW-1:0];
        state_nxt = bbs_pkg::ST_ACC;
      end

      bbs_pkg::ST_ACC: begin
        sum_nxt = sum_r + SUMW'(sq_r);
        if (ax_r == bbs_pkg::AXIS_Z) begin
          state_nxt = bbs_pkg::ST_CMP;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = bbs_pkg::ST_MUL;
        end
      end

      bbs_pkg::ST_CMP: begin
        if (sum_r > best_r) begin
          best_nxt = sum_r;
        end
        if (idx_r == cnt_r - CNT_W'(1)) begin
          val_nxt   = best_nxt;
          rem_nxt   = '0;
          root_nxt  = '0;
          it_nxt    = ITW'(RTW - 1);
          state_nxt = bbs_pkg::ST_SQRT;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = bbs_pkg::ST_READ;
        end
      end

      bbs_pkg::ST_SQRT: begin
        val_nxt = {val_r[SUMW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[RTW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[RTW-2:0], 1'b0};
        end
        it_nxt = it_r - ITW'(1);
        if (it_r == '0) begin
          state_nxt = bbs_pkg::ST_DONE;
        end
      end

      bbs_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.center_x = cx_r;
          out_data_nxt.center_y = cy_r;
          out_data_nxt.center_z = cz_r;
          out_data_nxt.extent_x = span_x[CW-1:1];
          out_data_nxt.extent_y = span_y[CW-1:1];
          out_data_nxt.extent_z = span_z[CW-1:1];
          out_data_nxt.radius   = root_r[CW-1:0];
          out_data_nxt.overflow = ovf_r;
          out_valid_nxt         = 1'b1;
          cnt_nxt               = '0;
          ovf_nxt               = 1'b0;
          state_nxt             = bbs_pkg::ST_LOAD;
        end
      end

      default: begin
        state_nxt = bbs_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbs_pkg::ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    min_x_r    <= min_x_nxt;
    min_y_r    <= min_y_nxt;
    min_z_r    <= min_z_nxt;
    max_x_r    <= max_x_nxt;
    max_y_r    <= max_y_nxt;
    max_z_r    <= max_z_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    ax_r       <= ax_nxt;
    sq_r       <= sq_nxt;
    sum_r      <= sum_nxt;
    best_r     <= best_nxt;
    val_r      <= val_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    it_r       <= it_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/tb_bounding_box_sphere.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for bounding_box_sphere: point sets in, one box/sphere result out.
// Depends on bbs_pkg and the bounding_box_sphere RTL.
module tb_bounding_box_sphere;

  localparam int COORD_BITS = bbs_pkg::COORD_BITS;
  localparam int DIFF_BITS  = bbs_pkg::DIFF_BITS;
  localparam int EXT_BITS   = bbs_pkg::EXT_BITS;
  typedef bbs_pkg::bbs_in_t  bbs_in_t;
  typedef bbs_pkg::bbs_out_t bbs_out_t;

  localparam int STORE_DEPTH = 1024;
  localparam int RANDOM_ITEMS = 380;
  localparam int REPORT_LIMIT = 10;
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = -32768;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = 32767;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bbs_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bbs_out_t out_data;

  bounding_box_sphere #(
    .MAX_POINTS(STORE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow copy of the current point set
  bbs_in_t                      held_pts[STORE_DEPTH];
  int                           held_count;
  logic signed [COORD_BITS-1:0] lo_x, lo_y, lo_z;
  logic signed [COORD_BITS-1:0] hi_x, hi_y, hi_z;
  logic                         spilled;

  bbs_out_t expected_bounds[$];
  int       mismatches;
  int       sent_items;
  bit       calm_input;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [COORD_BITS-1:0] floor_sqrt(input longint unsigned v);
    logic [COORD_BITS+1:0] root;
    logic [COORD_BITS+1:0] cand;
    root = '0;
    for (int b = COORD_BITS + 1; b >= 0; b--) begin
      cand = root | (18'd1 << b);
      if (longint'(cand) * longint'(cand) <= v) root = cand;
    end
    return root[COORD_BITS-1:0];
  endfunction

  // Fold one accepted point into the shadow set; on last point queue the result.
  task automatic track_point(input bbs_in_t p);
    bbs_out_t                     r;
    logic     [DIFF_BITS-1:0]     sx, sy, sz, ex, ey, ez;
    logic signed [COORD_BITS-1:0] cx, cy, cz;
    longint                       dx, dy, dz;
    longint unsigned              d2, far_sq;
    if (held_count < STORE_DEPTH) begin
      if (held_count == 0) begin
        lo_x = p.point_x; hi_x = p.point_x;
        lo_y = p.point_y; hi_y = p.point_y;
        lo_z = p.point_z; hi_z = p.point_z;
      end else begin
        if (p.point_x < lo_x) lo_x = p.point_x;
        if (p.point_y < lo_y) lo_y = p.point_y;
        if (p.point_z < lo_z) lo_z = p.point_z;
        if (p.point_x > hi_x) hi_x = p.point_x;
        if (p.point_y > hi_y) hi_y = p.point_y;
        if (p.point_z > hi_z) hi_z = p.point_z;
      end
      held_pts[held_count] = p;
      held_count++;
    end else begin
      spilled = 1'b1;
    end
    if (!p.last_point) return;

    // dropping the LSB of the 17-bit sum is floor division by two
    sx = {lo_x[COORD_BITS-1], lo_x} + {hi_x[COORD_BITS-1], hi_x};
    sy = {lo_y[COORD_BITS-1], lo_y} + {hi_y[COORD_BITS-1], hi_y};
    sz = {lo_z[COORD_BITS-1], lo_z} + {hi_z[COORD_BITS-1], hi_z};
    ex = {hi_x[COORD_BITS-1], hi_x} - {lo_x[COORD_BITS-1], lo_x};
    ey = {hi_y[COORD_BITS-1], hi_y} - {lo_y[COORD_BITS-1], lo_y};
    ez = {hi_z[COORD_BITS-1], hi_z} - {lo_z[COORD_BITS-1], lo_z};
    cx = sx[DIFF_BITS-1:1];
    cy = sy[DIFF_BITS-1:1];
    cz = sz[DIFF_BITS-1:1];

    far_sq = 0;
    for (int n = 0; n < held_count; n++) begin
      dx = longint'(held_pts[n].point_x) - longint'(cx);
      dy = longint'(held_pts[n].point_y) - longint'(cy);
      dz = longint'(held_pts[n].point_z) - longint'(cz);
      d2 = dx * dx + dy * dy + dz * dz;
      if (d2 > far_sq) far_sq = d2;
    end

    r.center_x = cx;
    r.center_y = cy;
    r.center_z = cz;
    r.extent_x = ex[EXT_BITS:1];
    r.extent_y = ey[EXT_BITS:1];
    r.extent_z = ez[EXT_BITS:1];
    r.radius   = floor_sqrt(far_sq);
    r.overflow = spilled;
    expected_bounds = {expected_bounds, r};

    held_count = 0;
    spilled    = 1'b0;
    lo_x = '0; lo_y = '0; lo_z = '0;
    hi_x = '0; hi_y = '0; hi_z = '0;
  endtask

  function automatic int pick_gap();
    int r;
    if (calm_input) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one item, hold it until accepted, then maybe idle.
  task automatic push_point(input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y,
                            input logic signed [COORD_BITS-1:0] z,
                            input logic last);
    bbs_in_t p;
    int      gap;
    p.point_x    = x;
    p.point_y    = y;
    p.point_z    = z;
    p.last_point = last;
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_point(p);
    sent_items++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [COORD_BITS-1:0] rand_coord(input int mode,
      input logic signed [COORD_BITS-1:0] base);
    case (mode)
      0: return COORD_BITS'($urandom);
      1: return base + $signed(COORD_BITS'($urandom_range(0, 511)) - 16'sd256);
      default: begin
        case ($urandom_range(0, 4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          3: return -16'sd1;
          default: return COORD_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic test_single_points();
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    push_point('0, '0, '0, 1'b1);
    push_point(COORD_MAX, COORD_MIN, -16'sd1, 1'b1);
  endtask

  task automatic test_extreme_spread();
    // widest box on every axis: largest extents and radius
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    push_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    push_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
  endtask

  task automatic test_floor_rounding();
    // odd sums, negative and positive, to exercise floor of half
    push_point(-16'sd3, 16'sd1, -16'sd1, 1'b0);
    push_point(16'sd0, 16'sd4, -16'sd2, 1'b1);
    push_point(-16'sd5, -16'sd7, 16'sd9, 1'b0);
    push_point(-16'sd2, -16'sd4, 16'sd2, 1'b0);
    push_point(-16'sd6, -16'sd1, 16'sd6, 1'b1);
  endtask

  task automatic test_mixed_small_sets();
    for (int s = 0; s < 3; s++) begin
      push_point(COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0);
      push_point(COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0);
      push_point(COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b1);
    end
  endtask

  task automatic test_store_overflow();
    // store filled exactly, then extra points are dropped; the one carrying last is dropped too
    for (int n = 0; n < STORE_DEPTH; n++)
      push_point(rand_coord(1, 16'sd0), rand_coord(1, 16'sd0), rand_coord(1, 16'sd0), 1'b0);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    push_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
    // next set must start clean
    push_point(16'sd100, -16'sd100, 16'sd7, 1'b1);
  endtask

  task automatic test_random_sets();
    int                           start_items;
    int                           set_len;
    int                           mode;
    int                           r;
    logic signed [COORD_BITS-1:0] bx, by, bz;
    start_items = sent_items;
    while (sent_items - start_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) set_len = $urandom_range(1, 6);
      else if (r < 95) set_len = $urandom_range(7, 40);
      else set_len = $urandom_range(100, 250);
      r = $urandom_range(0, 99);
      mode = (r < 50) ? 0 : (r < 85) ? 1 : 2;
      calm_input = ($urandom_range(0, 99) < 20);
      bx = COORD_BITS'($urandom);
      by = COORD_BITS'($urandom);
      bz = COORD_BITS'($urandom);
      for (int n = 0; n < set_len; n++)
        push_point(rand_coord(mode, bx), rand_coord(mode, by), rand_coord(mode, bz),
                   n == set_len - 1);
    end
    calm_input = 1'b0;
  endtask

  // Result receiver: random stalls, sometimes long clear stretches
  initial begin
    int on_len;
    int off_len;
    int r;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      r = $urandom_range(0, 99);
      on_len = (r < 15) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      r = $urandom_range(0, 99);
      off_len = (r < 40) ? 0 : (r < 92) ? $urandom_range(1, 4) : $urandom_range(15, 60);
      out_ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      if (off_len > 0) begin
        out_ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  // Result checker
  initial begin
    bbs_out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_bounds.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result at %0t: c=(%0d,%0d,%0d) r=%0d", $realtime,
                     $signed(out_data.center_x), $signed(out_data.center_y),
                     $signed(out_data.center_z), out_data.radius);
        end else begin
          want = expected_bounds.pop_front();
          if (out_data.center_x !== want.center_x || out_data.center_y !== want.center_y ||
              out_data.center_z !== want.center_z || out_data.extent_x !== want.extent_x ||
              out_data.extent_y !== want.extent_y || out_data.extent_z !== want.extent_z ||
              out_data.radius !== want.radius || out_data.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("mismatch at %0t", $realtime);
              $display("  exp c=(%0d,%0d,%0d) e=(%0d,%0d,%0d) r=%0d ov=%0b",
                       $signed(want.center_x), $signed(want.center_y),
                       $signed(want.center_z), want.extent_x, want.extent_y,
                       want.extent_z, want.radius, want.overflow);
              $display("  got c=(%0d,%0d,%0d) e=(%0d,%0d,%0d) r=%0d ov=%0b",
                       $signed(out_data.center_x), $signed(out_data.center_y),
                       $signed(out_data.center_z), out_data.extent_x, out_data.extent_y,
                       out_data.extent_z, out_data.radius, out_data.overflow);
            end
          end
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    held_count = 0;
    spilled    = 1'b0;
    lo_x = '0; lo_y = '0; lo_z = '0;
    hi_x = '0; hi_y = '0; hi_z = '0;
    mismatches = 0;
    sent_items = 0;
    calm_input = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_points();
    test_extreme_spread();
    test_floor_rounding();
    test_mixed_small_sets();
    test_store_overflow();
    test_random_sets();

    in_valid <= 1'b0;
    while (expected_bounds.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ bounding_box_sphere.f @@
hw/rtl/bbs_pkg.sv
hw/rtl/bbs_ram.sv
hw/rtl/bounding_box_sphere.sv
tb/tb_bounding_box_sphere.sv
